>>> hw/rtl/tlb_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tlb_pkg
// shared command, status and state codes for the tlb translator
// ---------------------------------------------------------------------------
package tlb_pkg;

    localparam int ADDR_BITS = 16;
    localparam int CFG_BITS  = 9;
    localparam int EVP_BITS  = 8;

    typedef struct packed {
        logic start;        // latch address, begin tlb search
        logic tlb_step;     // compare one tlb entry
        logic pm_read;      // issue page map read
        logic init_step;    // clear one page map / owner entry
        logic scan_start;   // begin frame scan
        logic scan_step;    // read or evaluate one frame in the scan
        logic own_read;     // read owner of chosen frame
        logic commit;       // apply updates, register result
    } tlb_cmd_t;

    typedef struct packed {
        logic tlb_done;
        logic tlb_found;
        logic pm_valid;
        logic scan_done;
        logic init_done;
    } tlb_sts_t;

    localparam logic [3:0] ST_INIT   = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_TLB    = 4'd2;
    localparam logic [3:0] ST_PMRD   = 4'd3;
    localparam logic [3:0] ST_PMCHK  = 4'd4;
    localparam logic [3:0] ST_SCAN   = 4'd5;
    localparam logic [3:0] ST_OWNRD  = 4'd6;
    localparam logic [3:0] ST_OWNCHK = 4'd7;
    localparam logic [3:0] ST_COMMIT = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;

endpackage : tlb_pkg
`default_nettype wire

>>> hw/rtl/tlb_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tlb_ctrl
// sequencer: init sweep, tlb search, page map check, frame scan, commit
// ---------------------------------------------------------------------------
module tlb_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire tlb_pkg::tlb_sts_t sts,
    output tlb_pkg::tlb_cmd_t    cmd
);
    import tlb_pkg::*;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.init_step = 1'b1;
                if (sts.init_done) state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_TLB;
                end
            end
            ST_TLB:
            begin
                cmd.tlb_step = 1'b1;
                // hit flag and frame land at this edge, commit next cycle
                if (sts.tlb_found)
                begin
                    state_next = ST_COMMIT;
                end
                else if (sts.tlb_done)
                begin
                    cmd.pm_read = 1'b1;
                    state_next  = ST_PMCHK;
                end
            end
            ST_PMRD:
            begin
                cmd.pm_read = 1'b1;
                state_next  = ST_PMCHK;
            end
            ST_PMCHK:
            begin
                if (sts.pm_valid)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) state_next = ST_OWNRD;
            end
            ST_OWNRD:
            begin
                cmd.own_read = 1'b1;
                state_next   = ST_OWNCHK;
            end
            ST_OWNCHK:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready) state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule : tlb_ctrl
`default_nettype wire

>>> hw/rtl/tlb_dpath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tlb_dpath
// tlb registers, page map, frame tables, lru scan and result register
// ---------------------------------------------------------------------------
module tlb_dpath #(
    parameter int PAGE_BITS   = 8,
    parameter int PAGE_COUNT  = 256,
    parameter int TLB_ENTRIES = 16,
    parameter int MAX_FRAMES  = 256,
    parameter int STAMP_BITS  = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tlb_pkg::tlb_cmd_t             cmd,
    output tlb_pkg::tlb_sts_t                  sts,
    input  wire logic [tlb_pkg::ADDR_BITS-1:0] virt_addr,
    input  wire logic                          cfg_valid,
    input  wire logic [tlb_pkg::CFG_BITS-1:0]  cfg_data,
    output logic [tlb_pkg::ADDR_BITS-1:0]      phys_addr,
    output logic                               tlb_hit,
    output logic                               page_fault,
    output logic                               evicted_valid,
    output logic [tlb_pkg::EVP_BITS-1:0]       evicted_page
);
    import tlb_pkg::*;

    localparam int PW = $clog2(PAGE_COUNT);
    localparam int FW = $clog2(MAX_FRAMES);
    localparam int TW = $clog2(TLB_ENTRIES);
    localparam int NW = FW + 1;
    localparam int IW = (PW > FW) ? PW : FW;
    localparam int IDEPTH = (PAGE_COUNT > MAX_FRAMES) ? PAGE_COUNT : MAX_FRAMES;
    localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

    // memories: page map {valid,frame}, owner {valid,page}, stamps
    logic [FW:0]           pm_mem  [PAGE_COUNT];
    logic [PW:0]           own_mem [MAX_FRAMES];
    logic [STAMP_BITS-1:0] stp_mem [MAX_FRAMES];

    logic                  tv_reg [TLB_ENTRIES];
    logic [PW-1:0]         tt_reg [TLB_ENTRIES];
    logic [FW-1:0]         tf_reg [TLB_ENTRIES];
    logic [TW-1:0]         fill_reg;
    logic [TW-1:0]         tidx_reg;
    logic [CFG_BITS-1:0]   cfg_reg;
    logic [STAMP_BITS-1:0] clk_reg;
    logic [IW:0]           init_reg;

    logic [PW-1:0]         page_reg;
    logic [PAGE_BITS-1:0]  off_reg;
    logic [FW-1:0]         frame_reg;
    logic                  hit_reg;
    logic [FW:0]           pm_rd_reg;
    logic [PW:0]           own_rd_reg;
    logic [PW:0]           scan_own_reg;
    logic [STAMP_BITS-1:0] scan_stp_reg;
    logic [NW-1:0]         sidx_reg;
    logic                  sphase_reg;
    logic [FW-1:0]         best_reg;
    logic [STAMP_BITS-1:0] best_stp_reg;

    logic [NW-1:0] usable;
    always_comb
    begin
        if (cfg_reg == '0) usable = NW'(1);
        else if (32'(cfg_reg) > MAX_FRAMES) usable = NW'(MAX_FRAMES);
        else usable = NW'(cfg_reg);
    end

    wire [PW-1:0] in_page = PW'(virt_addr >> PAGE_BITS);
    wire          t_match = tv_reg[tidx_reg] && (tt_reg[tidx_reg] == page_reg);
    wire          fault   = !hit_reg && !pm_rd_reg[FW];
    wire [FW-1:0] nframe  = fault ? best_reg : (hit_reg ? frame_reg : pm_rd_reg[FW-1:0]);
    wire          ev      = fault && own_rd_reg[PW];
    wire [PW-1:0] old_pg  = own_rd_reg[PW-1:0];

    assign sts.tlb_found = cmd.tlb_step && t_match;
    assign sts.tlb_done  = (tidx_reg == TW'(TLB_ENTRIES - 1));
    assign sts.pm_valid  = pm_rd_reg[FW];
    assign sts.init_done = (init_reg == (IW+1)'(IDEPTH - 1));
    // scan alternates read and evaluate phases
    assign sts.scan_done = sphase_reg && ((sidx_reg + NW'(1) >= usable) ||
                           !scan_own_reg[PW]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            cfg_reg  <= CFG_BITS'(256);
            clk_reg  <= '0;
            init_reg <= '0;
            for (int i = 0; i < TLB_ENTRIES; i++) tv_reg[i] <= 1'b0;
        end
        else
        begin
            if (cfg_valid) cfg_reg <= cfg_data;
            if (cmd.init_step && !sts.init_done) init_reg <= init_reg + 1'b1;
            if (cmd.commit)
            begin
                if (clk_reg != STAMP_MAX) clk_reg <= clk_reg + 1'b1;
                if (!hit_reg)
                begin
                    for (int i = 0; i < TLB_ENTRIES; i++)
                        if (ev && tv_reg[i] && tt_reg[i] == old_pg) tv_reg[i] <= 1'b0;
                    tv_reg[fill_reg] <= 1'b1;
                    fill_reg <= fill_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_step)
        begin
            if (32'(init_reg) < PAGE_COUNT) pm_mem[PW'(init_reg)] <= '0;
            if (32'(init_reg) < MAX_FRAMES)
            begin
                own_mem[FW'(init_reg)] <= '0;
                stp_mem[FW'(init_reg)] <= '0;
            end
        end
        if (cmd.start)
        begin
            page_reg <= in_page;
            off_reg  <= virt_addr[PAGE_BITS-1:0];
            tidx_reg <= '0;
            hit_reg  <= 1'b0;
        end
        if (cmd.tlb_step)
        begin
            if (t_match)
            begin
                hit_reg   <= 1'b1;
                frame_reg <= tf_reg[tidx_reg];
            end
            else tidx_reg <= tidx_reg + 1'b1;
        end
        if (cmd.pm_read) pm_rd_reg <= pm_mem[page_reg];
        if (cmd.scan_start)
        begin
            sidx_reg   <= '0;
            sphase_reg <= 1'b0;
            best_reg   <= '0;
        end
        if (cmd.scan_step)
        begin
            if (!sphase_reg)
            begin
                scan_own_reg <= own_mem[FW'(sidx_reg)];
                scan_stp_reg <= stp_mem[FW'(sidx_reg)];
                sphase_reg   <= 1'b1;
            end
            else
            begin
                sphase_reg <= 1'b0;
                sidx_reg   <= sidx_reg + 1'b1;
                if (!scan_own_reg[PW])
                    best_reg <= FW'(sidx_reg);
                else if (sidx_reg == '0 || scan_stp_reg < best_stp_reg)
                begin
                    best_reg     <= FW'(sidx_reg);
                    best_stp_reg <= scan_stp_reg;
                end
            end
        end
        if (cmd.own_read) own_rd_reg <= own_mem[best_reg];
        if (cmd.commit)
        begin
            stp_mem[nframe] <= clk_reg;
            if (fault)
            begin
                if (ev) pm_mem[old_pg] <= '0;
                pm_mem[page_reg] <= {1'b1, nframe};
                own_mem[nframe]  <= {1'b1, page_reg};
            end
            if (!hit_reg)
            begin
                tt_reg[fill_reg] <= page_reg;
                tf_reg[fill_reg] <= nframe;
            end
            phys_addr <= ADDR_BITS'(({{(ADDR_BITS){1'b0}}, nframe} << PAGE_BITS)
                         | {{(ADDR_BITS){1'b0}}, off_reg});
            tlb_hit       <= hit_reg;
            page_fault    <= fault;
            evicted_valid <= ev;
            evicted_page  <= ev ? EVP_BITS'(old_pg) : '0;
        end
    end

endmodule : tlb_dpath
`default_nettype wire

>>> hw/rtl/tlb_page_table_lru_translator_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tlb_page_table_lru_translator_top
// address translator with tlb, page map and lru frame replacement
// ---------------------------------------------------------------------------
// in channel: one 16-bit logical address per transfer (in_valid/in_ready)
// out channel: physical address and hit, fault, eviction flags
// cfg channel: frames_in_use, write only while idle
// a tlb hit searches the tlb one entry a cycle, stopping at the first matching
// entry, then commits; a tlb miss reads and checks the page map, and a page map
// hit commits; a fault adds a frame scan that reads each frame from the owner and
// stamp memories, then compares it, up to frames_in_use frames and stopping at a
// free frame, followed by owner read, owner check and commit
// each address passes through the result state, then idle, before the next is taken
// one address is in flight at a time; the result holds while out_ready is low
// and no new address is taken until it is transferred
// after reset a clearing pass over max(PAGE_COUNT, MAX_FRAMES) entries empties
// the page map and frame tables; in_ready stays low during it
// ---------------------------------------------------------------------------
module tlb_page_table_lru_translator_top #(
    parameter int PAGE_BITS   = 8,
    parameter int PAGE_COUNT  = 256,
    parameter int TLB_ENTRIES = 16,
    parameter int MAX_FRAMES  = 256,
    parameter int STAMP_BITS  = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [tlb_pkg::ADDR_BITS-1:0] virt_addr,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [tlb_pkg::ADDR_BITS-1:0]      phys_addr,
    output logic                               tlb_hit,
    output logic                               page_fault,
    output logic                               evicted_valid,
    output logic [tlb_pkg::EVP_BITS-1:0]       evicted_page,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tlb_pkg::CFG_BITS-1:0]  cfg_data
);
    import tlb_pkg::*;

    tlb_cmd_t cmd;
    tlb_sts_t sts;

    assign cfg_ready = 1'b1;

    tlb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tlb_dpath #(
        .PAGE_BITS   (PAGE_BITS),
        .PAGE_COUNT  (PAGE_COUNT),
        .TLB_ENTRIES (TLB_ENTRIES),
        .MAX_FRAMES  (MAX_FRAMES),
        .STAMP_BITS  (STAMP_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .virt_addr     (virt_addr),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .phys_addr     (phys_addr),
        .tlb_hit       (tlb_hit),
        .page_fault    (page_fault),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page)
    );

endmodule : tlb_page_table_lru_translator_top
`default_nettype wire

>>> tb/tlb_page_table_lru_translator_top_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlb_page_table_lru_translator_top_test
// drives logical addresses through the translator and checks each translation
// against a behavioral model of the tlb, page map and lru frame replacement
// ---------------------------------------------------------------------------
module tlb_page_table_lru_translator_top_test;

    import tlb_pkg::*;

    localparam int PAGE_TOTAL  = 256;
    localparam int NUM_TLB     = 16;
    localparam int FRAME_TOTAL = 256;
    localparam logic [31:0] CLOCK_MAX = 32'hFFFF_FFFF;
    localparam int CYCLE_LIMIT = 5000000;

    typedef struct packed {
        logic [ADDR_BITS-1:0] phys;
        logic                 hit;
        logic                 fault;
        logic                 ev_valid;
        logic [EVP_BITS-1:0]  ev_page;
    } xlat_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [ADDR_BITS-1:0] virt_addr;
    logic out_valid;
    logic out_ready;
    logic [ADDR_BITS-1:0] phys_addr;
    logic tlb_hit;
    logic page_fault;
    logic evicted_valid;
    logic [EVP_BITS-1:0] evicted_page;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_BITS-1:0] cfg_data;

    tlb_page_table_lru_translator_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .virt_addr(virt_addr),
        .out_valid(out_valid), .out_ready(out_ready),
        .phys_addr(phys_addr), .tlb_hit(tlb_hit),
        .page_fault(page_fault), .evicted_valid(evicted_valid),
        .evicted_page(evicted_page),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // translation model state
    logic [CFG_BITS-1:0] mdl_frames;
    logic        pm_ok    [PAGE_TOTAL];
    logic [7:0]  pm_frm   [PAGE_TOTAL];
    logic        tv       [NUM_TLB];
    logic [7:0]  ttag     [NUM_TLB];
    logic [7:0]  tfrm     [NUM_TLB];
    logic [3:0]  fill_ptr;
    logic        own_ok   [FRAME_TOTAL];
    logic [7:0]  own_pg   [FRAME_TOTAL];
    logic [31:0] stamp    [FRAME_TOTAL];
    logic [31:0] acc_clock;

    xlat_t expected_xlats[$];
    int errors = 0;
    int results_seen = 0;
    int faults_seen = 0;
    int hits_seen = 0;
    int evictions_seen = 0;
    longint cycles = 0;
    bit hold_off = 0;
    bit random_gaps = 1;

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL tlb_page_table_lru_translator_top");
            $finish;
        end
    end

    task automatic model_reset();
        mdl_frames = 9'd256;
        fill_ptr = 0;
        acc_clock = 0;
        for (int i = 0; i < PAGE_TOTAL; i++)
        begin
            pm_ok[i] = 0;
            pm_frm[i] = 0;
        end
        for (int i = 0; i < NUM_TLB; i++)
        begin
            tv[i] = 0;
            ttag[i] = 0;
            tfrm[i] = 0;
        end
        for (int i = 0; i < FRAME_TOTAL; i++)
        begin
            own_ok[i] = 0;
            own_pg[i] = 0;
            stamp[i] = 0;
        end
    endtask

    task automatic tlb_load(input logic [7:0] pg, input logic [7:0] frm);
        tv[fill_ptr] = 1;
        ttag[fill_ptr] = pg;
        tfrm[fill_ptr] = frm;
        fill_ptr = fill_ptr + 1;
    endtask

    function automatic int choose_frame();
        int n;
        int best;
        n = (mdl_frames == 0) ? 1 : (mdl_frames > FRAME_TOTAL ? FRAME_TOTAL : mdl_frames);
        for (int f = 0; f < n; f++)
            if (!own_ok[f])
                return f;
        best = 0;
        for (int f = 1; f < n; f++)
            if (stamp[f] < stamp[best])
                best = f;
        return best;
    endfunction

    task automatic translate(input logic [15:0] addr, output xlat_t r);
        logic [7:0] pg;
        logic [7:0] frm;
        logic [7:0] old;
        bit found;
        pg = addr[15:8];
        frm = 0;
        found = 0;
        r = '0;
        for (int i = 0; i < NUM_TLB; i++)
            if (!found && tv[i] && ttag[i] == pg)
            begin
                frm = tfrm[i];
                found = 1;
            end
        if (!found)
        begin
            if (pm_ok[pg])
            begin
                frm = pm_frm[pg];
                tlb_load(pg, frm);
            end
            else
            begin
                r.fault = 1;
                frm = 8'(choose_frame());
                if (own_ok[frm])
                begin
                    old = own_pg[frm];
                    r.ev_valid = 1;
                    r.ev_page = old;
                    pm_ok[old] = 0;
                    for (int i = 0; i < NUM_TLB; i++)
                        if (tv[i] && ttag[i] == old)
                            tv[i] = 0;
                end
                pm_ok[pg] = 1;
                pm_frm[pg] = frm;
                own_ok[frm] = 1;
                own_pg[frm] = pg;
                tlb_load(pg, frm);
            end
        end
        r.hit = found;
        stamp[frm] = acc_clock;
        if (acc_clock < CLOCK_MAX)
            acc_clock = acc_clock + 1;
        r.phys = {frm, addr[7:0]};
    endtask

    task automatic random_gap();
        int n;
        if (!random_gaps)
            return;
        n = $urandom_range(0, 99);
        if (n < 55)
            return;
        else if (n < 95)
            repeat ($urandom_range(1, 3)) @(negedge clk);
        else
            repeat ($urandom_range(10, 60)) @(negedge clk);
    endtask

    task automatic send_address(input logic [15:0] addr);
        xlat_t r;
        bit taken;
        random_gap();
        in_valid = 1;
        virt_addr = addr;
        taken = 0;
        while (!taken)
        begin
            // in_ready only moves at a rising edge, so the falling edge value holds
            taken = in_ready;
            @(posedge clk);
            if (!taken)
                @(negedge clk);
        end
        translate(addr, r);
        expected_xlats.push_back(r);
        @(negedge clk);
        in_valid = 0;
    endtask

    task automatic drain();
        while (expected_xlats.size() != 0)
            @(negedge clk);
        // a result leaves the block before it is idle again
        repeat (8) @(negedge clk);
    endtask

    task automatic write_frames(input logic [CFG_BITS-1:0] val);
        drain();
        cfg_valid = 1;
        cfg_data = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mdl_frames = val;
        @(negedge clk);
        cfg_valid = 0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        xlat_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_xlats.size() == 0)
            begin
                $error("result with no pending translation");
                errors++;
            end
            else
            begin
                e = expected_xlats.pop_front();
                results_seen++;
                if (tlb_hit) hits_seen++;
                if (page_fault) faults_seen++;
                if (evicted_valid) evictions_seen++;
                if (phys_addr !== e.phys)
                begin
                    $error("phys_addr exp %h got %h", e.phys, phys_addr);
                    errors++;
                end
                if (tlb_hit !== e.hit)
                begin
                    $error("tlb_hit exp %b got %b", e.hit, tlb_hit);
                    errors++;
                end
                if (page_fault !== e.fault)
                begin
                    $error("page_fault exp %b got %b", e.fault, page_fault);
                    errors++;
                end
                if (evicted_valid !== e.ev_valid)
                begin
                    $error("evicted_valid exp %b got %b", e.ev_valid, evicted_valid);
                    errors++;
                end
                if (evicted_page !== e.ev_page)
                begin
                    $error("evicted_page exp %h got %h", e.ev_page, evicted_page);
                    errors++;
                end
            end
        end
    end

    // receiver backpressure
    initial
    begin
        out_ready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                out_ready <= 0;
            else if (!random_gaps)
                out_ready <= 1;
            else
                out_ready <= ($urandom_range(0, 99) < 75);
        end
    end

    task automatic test_directed();
        write_frames(9'd4);
        send_address(16'h0000);
        send_address(16'hFFFF);
        send_address(16'h0000);       // tlb hit
        send_address(16'h5555);
        send_address(16'hAAAA);
        send_address(16'h01FF);       // lru eviction of a mapped page
        send_address(16'hFF00);
        send_address(16'h0080);
        write_frames(9'd0);           // zero frames acts as one
        send_address(16'h1234);
        send_address(16'h4321);
        write_frames(9'd511);         // oversize saturates to all frames
        send_address(16'h7F7F);
        send_address(16'h8001);
        write_frames(9'd2);           // shrunk: high frames still translate
        send_address(16'h7F00);
        send_address(16'h8000);
        send_address(16'h3C3C);
        send_address(16'hC3C3);
        write_frames(9'd256);
    endtask

    // repeated pages through one tlb slot rotation refill and page map hits
    task automatic test_tlb_pressure();
        write_frames(9'd64);
        for (int i = 0; i < 60; i++)
            send_address({8'($urandom_range(0, 23)), 8'($urandom)});
    endtask

    task automatic test_backpressure();
        hold_off = 1;
        fork
            begin
                repeat (300) @(negedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 6; i++)
                send_address(16'($urandom));
        join
        drain();
        random_gaps = 0;
        for (int i = 0; i < 20; i++)
            send_address({8'($urandom_range(0, 7)), 8'($urandom)});
        random_gaps = 1;
    endtask

    task automatic test_random();
        logic [CFG_BITS-1:0] settings[6] = '{9'd1, 9'd3, 9'd16, 9'd40, 9'd256, 9'd300};
        for (int phase = 0; phase < 6; phase++)
        begin
            write_frames(settings[phase]);
            for (int i = 0; i < 275; i++)
            begin
                int k;
                k = $urandom_range(0, 99);
                // mostly a small working set, some wide spread
                if (k < 70)
                    send_address({8'($urandom_range(0, 47)), 8'($urandom)});
                else
                    send_address(16'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        virt_addr = 0;
        cfg_valid = 0;
        cfg_data = 0;
        model_reset();
        repeat (2) @(negedge clk);
        rst_n = 1;
        test_directed();
        test_tlb_pressure();
        test_backpressure();
        test_random();
        drain();
        repeat (20) @(negedge clk);
        if (expected_xlats.size() != 0)
            errors++;
        $display("covered %0d translations: %0d tlb hits, %0d faults, %0d evictions",
            results_seen, hits_seen, faults_seen, evictions_seen);
        $display("frame counts from zero to oversize, with long output stalls");
        if (errors == 0)
            $display("PASS tlb_page_table_lru_translator_top");
        else
            $display("FAIL tlb_page_table_lru_translator_top");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/tlb_pkg.sv
hw/rtl/tlb_ctrl.sv
hw/rtl/tlb_dpath.sv
hw/rtl/tlb_page_table_lru_translator_top.sv
tb/tlb_page_table_lru_translator_top_test.sv
